// ===== rtl/core/qte_pkg.sv =====
// Shared constants and angle table for the quaternion to Euler angle pipeline.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

	localparam int ANGLE_STAGES_DEF   = 16;
	localparam int QUAT_FRAC_BITS_DEF = 14;
	localparam int TABLE_LEN          = 24;
	// angle word: units of 2^-22 degree
	localparam int ZW                 = 33;
	// square root: 61 bit radicand, one result bit per cell
	localparam int SQRT_STEPS         = 31;
	localparam int RW                 = 62;
	localparam int AW                 = 32;
	localparam int OW                 = ZW - 16;

	localparam logic signed [ZW-1:0] DEG90    = 33'sd377487360;
	localparam logic signed [ZW-1:0] DEG180   = 33'sd754974720;
	localparam logic signed [AW-1:0] ONE_Q30  = 32'sd1073741824;
	localparam logic signed [ZW-1:0] HALF_LSB = 33'sd32768;

	localparam logic signed [OW-1:0] ROLL_MAX  = 17'sd11520;
	localparam logic signed [OW-1:0] PITCH_MAX = 17'sd5760;
	localparam logic signed [OW-1:0] YAW_MAX   = 17'sd23040;

	// atan(2^-i) in units of 2^-22 degree
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:       v = 33'sd188743680;
			1:       v = 33'sd111421900;
			2:       v = 33'sd58872272;
			3:       v = 33'sd29884485;
			4:       v = 33'sd15000234;
			5:       v = 33'sd7507429;
			6:       v = 33'sd3754631;
			7:       v = 33'sd1877430;
			8:       v = 33'sd938729;
			9:       v = 33'sd469366;
			10:      v = 33'sd234683;
			11:      v = 33'sd117342;
			12:      v = 33'sd58671;
			13:      v = 33'sd29335;
			14:      v = 33'sd14668;
			15:      v = 33'sd7334;
			16:      v = 33'sd3667;
			17:      v = 33'sd1833;
			18:      v = 33'sd917;
			19:      v = 33'sd458;
			20:      v = 33'sd229;
			21:      v = 33'sd115;
			22:      v = 33'sd57;
			23:      v = 33'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// Quaternion (ZYX) to roll, pitch and yaw: products, square root chain, CORDIC chains.
//
//  port group        | dir | handshake
//  start, quat_*     | in  | taken when start && !busy
//  done, *_angle,    | out | done high one cycle per result, no backpressure
//  pitch_clamped     |     |
//
// One request per cycle; busy is always low.
// Pipeline: 3 front stages, 31 square root cells,
// one quadrant stage, ANGLE_STAGES CORDIC cells, one output stage.
// Reset clears only the valid pipeline; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles #(
	parameter int ANGLE_STAGES   = qte_pkg::ANGLE_STAGES_DEF,
	parameter int QUAT_FRAC_BITS = qte_pkg::QUAT_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	output logic                    done,
	output logic signed [14:0]      roll_angle,
	output logic signed [13:0]      pitch_angle,
	output logic        [14:0]      yaw_angle,
	output logic                    pitch_clamped
);
	import qte_pkg::*;

	localparam int F2    = 2 * QUAT_FRAC_BITS;
	localparam int RAWW  = ((F2 > 32) ? F2 : 32) + 3;
	localparam int QW    = (((62 - F2) > 32) ? (62 - F2) : 32) + 2;
	localparam int CW    = QW + 2;
	localparam int WIDEW = RAWW + 32;
	localparam int SH_R  = (F2 >= 30) ? (F2 - 30) : 0;
	localparam int SH_L  = (F2 < 30) ? (30 - F2) : 0;
	localparam int LAT   = 3 + SQRT_STEPS + 1 + ANGLE_STAGES + 1;
	localparam int DLW   = 4 * QW + AW + 1;
	localparam logic signed [RAWW-1:0] HALF = RAWW'(1) <<< (F2 - 1);

	function automatic logic signed [QW-1:0] to_q30(input logic signed [RAWW-1:0] v);
		logic signed [WIDEW-1:0] e;
		e = WIDEW'(v);
		e = (e >>> SH_R) <<< SH_L;
		return e[QW-1:0];
	endfunction

	function automatic logic signed [OW-1:0] to_64th(input logic signed [ZW-1:0] z,
			input logic signed [OW-1:0] lo, input logic signed [OW-1:0] hi);
		logic signed [ZW-1:0] t;
		logic signed [OW-1:0] a;
		t = (z + HALF_LSB) >>> 16;
		a = t[OW-1:0];
		if (a < lo) a = lo;
		if (a > hi) a = hi;
		return a;
	endfunction

	// valid pipeline
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	// stage 1: products
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, xy_s1, wz_s1, zz_s1, xz_s1, wy_s1;

	always_ff @(posedge clk) begin
		wx_s1 <= quat_w * quat_x;
		yz_s1 <= quat_y * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		xy_s1 <= quat_x * quat_y;
		wz_s1 <= quat_w * quat_z;
		zz_s1 <= quat_z * quat_z;
		xz_s1 <= quat_x * quat_z;
		wy_s1 <= quat_w * quat_y;
	end

	// stage 2: sums in Q30, asin argument saturated
	logic signed [RAWW-1:0] a_raw;
	logic signed [QW-1:0]   a_q30;
	logic signed [QW-1:0]   ry_s2, rx_s2, yy2_s2, yx_s2;
	logic signed [AW-1:0]   a_s2;
	logic                   clamp_s2;

	assign a_raw = (RAWW'(wy_s1) - RAWW'(xz_s1)) <<< 1;
	assign a_q30 = to_q30(a_raw);

	always_ff @(posedge clk) begin
		ry_s2  <= to_q30(RAWW'(wx_s1) + RAWW'(yz_s1));
		rx_s2  <= to_q30(HALF - RAWW'(xx_s1) - RAWW'(yy_s1));
		yy2_s2 <= to_q30(RAWW'(xy_s1) + RAWW'(wz_s1));
		yx_s2  <= to_q30(HALF - RAWW'(yy_s1) - RAWW'(zz_s1));
		if (a_q30 > QW'(ONE_Q30)) begin
			a_s2     <= ONE_Q30;
			clamp_s2 <= 1'b1;
		end else if (a_q30 < -QW'(ONE_Q30)) begin
			a_s2     <= -ONE_Q30;
			clamp_s2 <= 1'b1;
		end else begin
			a_s2     <= a_q30[AW-1:0];
			clamp_s2 <= 1'b0;
		end
	end

	// stage 3: a^2
	logic [AW-1:0]  a_mag;
	logic [RW-1:0]  asq_s3;
	logic [DLW-1:0] pay_s3;

	assign a_mag = a_s2[AW-1] ? AW'(-a_s2) : AW'(a_s2);

	always_ff @(posedge clk) begin
		asq_s3 <= RW'(a_mag[AW-2:0]) * RW'(a_mag[AW-2:0]);
		pay_s3 <= {clamp_s2, a_s2, yx_s2, yy2_s2, rx_s2, ry_s2};
	end

	// square root chain, payload delayed alongside
	logic [RW-1:0]  rem_c  [SQRT_STEPS];
	logic [RW-1:0]  root_c [SQRT_STEPS];
	logic [DLW-1:0] pay_q  [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [RW-1:0] rem_i, root_i;
		if (k == 0) begin : g_first
			assign rem_i  = (RW'(1) << 60) - asq_s3;
			assign root_i = '0;
			always_ff @(posedge clk) begin
				pay_q[k] <= pay_s3;
			end
		end else begin : g_next
			assign rem_i  = rem_c[k-1];
			assign root_i = root_c[k-1];
			always_ff @(posedge clk) begin
				pay_q[k] <= pay_q[k-1];
			end
		end
		qte_sqrt_cell #(.SHIFT(60 - 2 * k)) u_cell (
			.clk      (clk),
			.rem_in   (rem_i),
			.root_in  (root_i),
			.rem_out  (rem_c[k]),
			.root_out (root_c[k])
		);
	end

	// quadrant stage: 0 roll, 1 yaw, 2 pitch
	logic [DLW-1:0]       pay_d;
	logic signed [CW-1:0] in_y [3];
	logic signed [CW-1:0] in_x [3];
	logic signed [CW-1:0] pre_x_q [3];
	logic signed [CW-1:0] pre_y_q [3];
	logic signed [ZW-1:0] pre_z_q [3];
	logic                 pre_zero_q [3];
	logic                 clamp_q [ANGLE_STAGES+1];

	assign pay_d = pay_q[SQRT_STEPS-1];
	assign in_y[0] = CW'(signed'(pay_d[QW-1:0]));
	assign in_x[0] = CW'(signed'(pay_d[2*QW-1:QW]));
	assign in_y[1] = CW'(signed'(pay_d[3*QW-1:2*QW]));
	assign in_x[1] = CW'(signed'(pay_d[4*QW-1:3*QW]));
	assign in_y[2] = CW'(signed'(pay_d[4*QW+AW-1:4*QW]));
	assign in_x[2] = CW'(root_c[SQRT_STEPS-1]);

	for (genvar c = 0; c < 3; c++) begin : g_pre
		always_ff @(posedge clk) begin
			pre_zero_q[c] <= (in_x[c] == '0) && (in_y[c] == '0);
			if (in_x[c][CW-1] && !in_y[c][CW-1]) begin
				pre_x_q[c] <= in_y[c];
				pre_y_q[c] <= -in_x[c];
				pre_z_q[c] <= DEG90;
			end else if (in_x[c][CW-1]) begin
				pre_x_q[c] <= -in_y[c];
				pre_y_q[c] <= in_x[c];
				pre_z_q[c] <= -DEG90;
			end else begin
				pre_x_q[c] <= in_x[c];
				pre_y_q[c] <= in_y[c];
				pre_z_q[c] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		clamp_q[0] <= pay_d[DLW-1];
		for (int s = 1; s <= ANGLE_STAGES; s++) begin
			clamp_q[s] <= clamp_q[s-1];
		end
	end

	// CORDIC chains
	logic signed [CW-1:0] cx [3][ANGLE_STAGES];
	logic signed [CW-1:0] cy [3][ANGLE_STAGES];
	logic signed [ZW-1:0] cz [3][ANGLE_STAGES];
	logic                 czero [3][ANGLE_STAGES];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		for (genvar s = 0; s < ANGLE_STAGES; s++) begin : g_stage
			logic signed [CW-1:0] xi, yi;
			logic signed [ZW-1:0] zi;
			logic                 zri;
			if (s == 0) begin : g_head
				assign xi  = pre_x_q[c];
				assign yi  = pre_y_q[c];
				assign zi  = pre_z_q[c];
				assign zri = pre_zero_q[c];
			end else begin : g_link
				assign xi  = cx[c][s-1];
				assign yi  = cy[c][s-1];
				assign zi  = cz[c][s-1];
				assign zri = czero[c][s-1];
			end
			qte_cordic_cell #(.W(CW), .STAGE(s)) u_cell (
				.clk      (clk),
				.x_in     (xi),
				.y_in     (yi),
				.z_in     (zi),
				.zero_in  (zri),
				.x_out    (cx[c][s]),
				.y_out    (cy[c][s]),
				.z_out    (cz[c][s]),
				.zero_out (czero[c][s])
			);
		end
	end

	// output stage
	logic signed [ZW-1:0] roll_z, yaw_z, pitch_z;
	logic signed [OW-1:0] roll_r, yaw_r, pitch_r;
	logic signed [14:0]   roll_q;
	logic signed [13:0]   pitch_q;
	logic        [14:0]   yaw_q;
	logic                 clamped_q;

	assign roll_z  = czero[0][ANGLE_STAGES-1] ? '0 : cz[0][ANGLE_STAGES-1];
	assign yaw_z   = (czero[1][ANGLE_STAGES-1] ? '0 : cz[1][ANGLE_STAGES-1]) + DEG180;
	assign pitch_z = cz[2][ANGLE_STAGES-1];
	assign roll_r  = to_64th(roll_z, -ROLL_MAX, ROLL_MAX);
	assign yaw_r   = to_64th(yaw_z, '0, YAW_MAX);
	assign pitch_r = to_64th(pitch_z, -PITCH_MAX, PITCH_MAX);

	always_ff @(posedge clk) begin
		roll_q    <= roll_r[14:0];
		pitch_q   <= pitch_r[13:0];
		yaw_q     <= yaw_r[14:0];
		clamped_q <= clamp_q[ANGLE_STAGES];
	end

	assign roll_angle    = roll_q;
	assign pitch_angle   = pitch_q;
	assign yaw_angle     = yaw_q;
	assign pitch_clamped = clamped_q;

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (roll_angle <= 15'sd11520) && (roll_angle >= -15'sd11520))
		else $error("roll out of range");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_angle <= 14'sd5760) && (pitch_angle >= -14'sd5760))
		else $error("pitch out of range");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (yaw_angle <= 15'd23040))
		else $error("yaw out of range");

endmodule
`default_nettype wire

// ===== rtl/core/qte_sqrt_cell.sv =====
// One restoring square root step: settles one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell #(
	parameter int SHIFT = 60
) (
	input  wire logic                   clk,
	input  wire logic [qte_pkg::RW-1:0] rem_in,
	input  wire logic [qte_pkg::RW-1:0] root_in,
	output logic      [qte_pkg::RW-1:0] rem_out,
	output logic      [qte_pkg::RW-1:0] root_out
);
	import qte_pkg::*;

	localparam logic [RW-1:0] BIT_VAL = RW'(1) << SHIFT;

	logic [RW-1:0] trial;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] root_q;

	assign trial = root_in + BIT_VAL;

	always_ff @(posedge clk) begin
		if (rem_in >= trial) begin
			rem_q  <= rem_in - trial;
			root_q <= (root_in >> 1) + BIT_VAL;
		end else begin
			rem_q  <= rem_in;
			root_q <= root_in >> 1;
		end
	end

	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule
`default_nettype wire

// ===== rtl/core/qte_cordic_cell.sv =====
// One vectoring CORDIC rotation with a fixed shift and angle step.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell #(
	parameter int W     = 37,
	parameter int STAGE = 0
) (
	input  wire logic                          clk,
	input  wire logic signed [W-1:0]           x_in,
	input  wire logic signed [W-1:0]           y_in,
	input  wire logic signed [qte_pkg::ZW-1:0] z_in,
	input  wire logic                          zero_in,
	output logic signed      [W-1:0]           x_out,
	output logic signed      [W-1:0]           y_out,
	output logic signed      [qte_pkg::ZW-1:0] z_out,
	output logic                               zero_out
);
	import qte_pkg::*;

	localparam logic signed [ZW-1:0] STEP = atan_entry(STAGE);

	logic signed [W-1:0]  dx, dy;
	logic signed [W-1:0]  x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic                 zero_q;

	assign dx = y_in >>> STAGE;
	assign dy = x_in >>> STAGE;

	always_ff @(posedge clk) begin
		zero_q <= zero_in;
		if (!y_in[W-1]) begin
			x_q <= x_in + dx;
			y_q <= y_in - dy;
			z_q <= z_in + STEP;
		end else begin
			x_q <= x_in - dx;
			y_q <= y_in + dy;
			z_q <= z_in - STEP;
		end
	end

	assign x_out    = x_q;
	assign y_out    = y_q;
	assign z_out    = z_q;
	assign zero_out = zero_q;

endmodule
`default_nettype wire
